// ===== sv/sync_word_frame_deframer_assert.svh =====
// ----------------------------------------------------------------------------
// sync_word_frame_deframer_assert.svh
// Assertion macros shared by the deframer RTL.
// ----------------------------------------------------------------------------
`ifndef SYNC_WORD_FRAME_DEFRAMER_ASSERT_SVH
`define SYNC_WORD_FRAME_DEFRAMER_ASSERT_SVH

// same-cycle implication
`define SWFD_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");

// next-cycle implication
`define SWFD_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

// ===== sv/swfd_pkg.sv =====
// ----------------------------------------------------------------------------
// swfd_pkg
// Types and constants of the sync word frame deframer.
// ----------------------------------------------------------------------------
package swfd_pkg;

   localparam int POS_W        = 6;
   localparam int DROP_W       = 16;
   localparam int SYNC_LEN     = 4;
   localparam int PAYLOAD_LAST = 11;

   localparam logic [7:0] SYNC_WORD [SYNC_LEN] = '{8'h00, 8'hAC, 8'hDD, 8'hDD};

   typedef struct packed {
      logic signed [31:0] rotor_position;
      logic [31:0]        encoder_count;
      logic [DROP_W-1:0]  dropped_bytes;
   } swfd_result_type;

   typedef struct packed {
      logic             hunting;
      logic [POS_W-1:0] frame_pos;
   } swfd_status_type;

endpackage

// ===== sv/swfd_in_reg.sv =====
// ----------------------------------------------------------------------------
// swfd_in_reg
// Input register: holds one received byte until the core takes it.
// ----------------------------------------------------------------------------
module swfd_in_reg
   import swfd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   input  logic       advance,
   output logic       byte_valid,
   output logic [7:0] byte_data
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;

   assign req_stall = valid_ff & ~advance;

   always_comb begin
      valid_in = req_stall ? valid_ff : req_valid;
      byte_in  = (req_valid & ~req_stall) ? req_rx_byte : byte_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
   end

   assign byte_valid = valid_ff & advance;
   assign byte_data  = byte_ff;

endmodule

// ===== sv/swfd_core.sv =====
// ----------------------------------------------------------------------------
// swfd_core
// Sync hunt, frame position, payload shift and drop count for one byte.
// ----------------------------------------------------------------------------
module swfd_core
   import swfd_pkg::*;
#(
   parameter int FRAME_BYTES = 12
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            byte_valid,
   input  logic [7:0]      byte_data,
   output logic            res_valid,
   output swfd_result_type res,
   output swfd_status_type status
);

   localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);

   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [63:0]       shift_ff, shift_in;
   logic [DROP_W-1:0] drop_ff, drop_in;
   logic [DROP_W:0]   drop_sum;
   logic [63:0]       shifted;
   logic [63:0]       payload;
   logic              hunting;
   logic              sync_hit;
   logic              first_hit;

   assign hunting   = pos_ff < POS_W'(SYNC_LEN);
   assign sync_hit  = byte_data == SYNC_WORD[pos_ff[1:0]];
   assign first_hit = byte_data == SYNC_WORD[0];
   assign shifted   = {byte_data, shift_ff[63:8]};
   // bytes past the encoder count leave the payload as it is
   assign payload   = (pos_ff <= POS_W'(PAYLOAD_LAST)) ? shifted : shift_ff;

   // partial match plus the byte itself when it is no first sync byte
   assign drop_sum = {1'b0, drop_ff} + (DROP_W+1)'(pos_ff[1:0])
                   + (DROP_W+1)'(!first_hit);

   always_comb begin
      pos_in    = pos_ff;
      shift_in  = shift_ff;
      drop_in   = drop_ff;
      res_valid = 1'b0;
      res.rotor_position = payload[31:0];
      res.encoder_count  = payload[63:32];
      res.dropped_bytes  = drop_ff;
      if (byte_valid) begin
         if (hunting) begin
            if (sync_hit) begin
               pos_in = pos_ff + POS_W'(1);
            end else begin
               drop_in = drop_sum[DROP_W] ? {DROP_W{1'b1}} : drop_sum[DROP_W-1:0];
               pos_in  = first_hit ? POS_W'(1) : '0;
            end
         end else begin
            if (pos_ff <= POS_W'(PAYLOAD_LAST)) begin
               shift_in = shifted;
            end
            if (pos_ff == LAST_POS) begin
               res_valid = 1'b1;
               pos_in    = '0;
               shift_in  = '0;
               drop_in   = '0;
            end else begin
               pos_in = pos_ff + POS_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         shift_ff <= '0;
         drop_ff  <= '0;
      end else begin
         pos_ff   <= pos_in;
         shift_ff <= shift_in;
         drop_ff  <= drop_in;
      end
   end

   assign status.hunting   = hunting;
   assign status.frame_pos = pos_ff;

endmodule

// ===== sv/swfd_out_reg.sv =====
// ----------------------------------------------------------------------------
// swfd_out_reg
// Result register: holds a finished frame until the receiver takes it.
// ----------------------------------------------------------------------------
module swfd_out_reg
   import swfd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               res_valid,
   input  swfd_result_type    res,
   output logic               advance,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_rotor_position,
   output logic [31:0]        rsp_encoder_count,
   output logic [DROP_W-1:0]  rsp_dropped_bytes
);

   logic            valid_ff, valid_in;
   swfd_result_type res_ff, res_in;

   assign advance = ~valid_ff | ~rsp_stall;

   always_comb begin
      valid_in = advance ? res_valid : valid_ff;
      res_in   = (advance & res_valid) ? res : res_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      res_ff <= res_in;
   end

   assign rsp_valid          = valid_ff;
   assign rsp_rotor_position = res_ff.rotor_position;
   assign rsp_encoder_count  = res_ff.encoder_count;
   assign rsp_dropped_bytes  = res_ff.dropped_bytes;

endmodule

// ===== sv/sync_word_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// sync_word_frame_deframer
// Hunts for sync word 00 AC DD DD in a byte stream and emits one result
// per frame: rotor position, encoder count and bytes dropped while hunting.
//
// req channel: one received byte per transfer (req_rx_byte).
// rsp channel: one transfer per completed frame of FRAME_BYTES bytes.
// Both channels: transfer when valid is high and stall is low.
// Throughput: one byte per cycle while the receiver does not stall, set by
// the combinational core between the input register and the result register.
// Path: the last frame byte is held in the input register, the core completes
// the frame, and the result register then raises rsp_valid.
// Reset: position back to the first sync byte, drop count and payload
// cleared, both registers empty.
// Receiver stall: the result register holds; one more byte is taken into
// the input register, then req_stall rises until the result is taken.
// ----------------------------------------------------------------------------
module sync_word_frame_deframer
   import swfd_pkg::*;
#(
   parameter int FRAME_BYTES = 12
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_rx_byte,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_rotor_position,
   output logic [31:0]        rsp_encoder_count,
   output logic [15:0]        rsp_dropped_bytes
);

`include "sync_word_frame_deframer_assert.svh"

   logic            advance;
   logic            byte_valid;
   logic [7:0]      byte_data;
   logic            res_valid;
   swfd_result_type res;
   swfd_status_type status;

   swfd_in_reg u_in_reg (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .advance     (advance),
      .byte_valid  (byte_valid),
      .byte_data   (byte_data)
   );

   swfd_core #(
      .FRAME_BYTES (FRAME_BYTES)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (byte_valid),
      .byte_data  (byte_data),
      .res_valid  (res_valid),
      .res        (res),
      .status     (status)
   );

   swfd_out_reg u_out_reg (
      .clock              (clock),
      .reset              (reset),
      .res_valid          (res_valid),
      .res                (res),
      .advance            (advance),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_rotor_position (rsp_rotor_position),
      .rsp_encoder_count  (rsp_encoder_count),
      .rsp_dropped_bytes  (rsp_dropped_bytes)
   );

   `SWFD_ASSERT_NOW(a_pos_in_frame, clock, reset, 1'b1,
      status.frame_pos <= POS_W'(FRAME_BYTES - 1))
   `SWFD_ASSERT_NEXT(a_frame_restarts_hunt, clock, reset, res_valid,
      status.hunting && status.frame_pos == '0 && rsp_valid)
   `SWFD_ASSERT_NOW(a_stall_only_when_full, clock, reset, req_stall,
      rsp_valid && rsp_stall)

endmodule
